// File: hw/rtl/button_direction_qualifier_assert.svh
// Assertion macros for the direction qualifier checker
`ifndef BUTTON_DIRECTION_QUALIFIER_ASSERT_SVH
`define BUTTON_DIRECTION_QUALIFIER_ASSERT_SVH

// clocked assertion, off while reset is held
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define BDQ_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bdq_pkg.sv
package bdq_pkg;

  localparam int BDQ_NUM_BUTTONS = 32;

  localparam logic [1:0] FN_PRESS   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_TICK    = 2'd2;

  localparam logic [3:0] HDG_NONE       = 4'd0;
  localparam logic [3:0] HDG_UP         = 4'd1;
  localparam logic [3:0] HDG_UP_RIGHT   = 4'd2;
  localparam logic [3:0] HDG_RIGHT      = 4'd3;
  localparam logic [3:0] HDG_DOWN_RIGHT = 4'd4;
  localparam logic [3:0] HDG_DOWN       = 4'd5;
  localparam logic [3:0] HDG_DOWN_LEFT  = 4'd6;
  localparam logic [3:0] HDG_LEFT       = 4'd7;
  localparam logic [3:0] HDG_UP_LEFT    = 4'd8;

  localparam int KEY_UP         = 0;
  localparam int KEY_DOWN       = 1;
  localparam int KEY_LEFT       = 2;
  localparam int KEY_RIGHT      = 3;
  localparam int KEY_UP_LEFT    = 4;
  localparam int KEY_UP_RIGHT   = 5;
  localparam int KEY_DOWN_LEFT  = 6;
  localparam int KEY_DOWN_RIGHT = 7;
  localparam int NUM_DIR_BTNS   = 8;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] button;
    logic [4:0] source;
  } bdq_evt_t;

  typedef struct packed {
    logic [3:0] heading;
    logic       move_active;
    logic       push_res;
    logic       button_held;
    logic       pressed_edge;
    logic       released_edge;
    logic       accepted;
  } bdq_res_t;

  typedef struct packed {
    logic [7:0] diagonal_hold_frames;
  } bdq_cfg_t;

endpackage

// File: hw/rtl/bdq_chan_if.sv
interface bdq_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// File: hw/rtl/button_direction_qualifier.sv
// Path: an event word is taken into the input register, then the qualify logic
// writes its result word into the result register.
// Throughput: one event word per cycle while results are taken; the input and
// result registers form a two-word buffer, so an event is taken while a result waits if the input register is empty.
// Reset: all hold and edge masks clear, heading is up, hold frames zero.
module button_direction_qualifier
  import bdq_pkg::*;
#(
  parameter int NUM_BUTTONS = BDQ_NUM_BUTTONS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdq_chan_if.sink   evt_i,
  bdq_chan_if.source res_o,
  bdq_chan_if.sink   cfg_i
);

  logic       s1_valid_q;
  bdq_evt_t   s1_evt_q;
  logic       res_valid_q;
  bdq_res_t   res_q;
  bdq_res_t   core_res;
  logic [7:0] hold_q;
  logic       advance;

  assign advance     = s1_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !s1_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  bdq_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (advance),
    .evt_i         (s1_evt_q),
    .hold_frames_i (hold_q),
    .res_o         (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      hold_q      <= 8'd0;
    end else begin
      if (evt_i.valid && evt_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        hold_q <= cfg_i.data.diagonal_hold_frames;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      s1_evt_q <= evt_i.data;
    end
    if (advance) begin
      res_q <= core_res;
    end
  end

endmodule

// File: hw/rtl/bdq_core.sv
module bdq_core
  import bdq_pkg::*;
#(
  parameter int NUM_BUTTONS = BDQ_NUM_BUTTONS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  bdq_evt_t   evt_i,
  input  logic [7:0] hold_frames_i,
  output bdq_res_t   res_o
);

  // only 32 buttons can be addressed
  localparam int NumStored = (NUM_BUTTONS < 32) ? NUM_BUTTONS : 32;
  localparam int IdxW      = $clog2(NumStored);
  localparam logic [6:0] NumBtnV = 7'(NUM_BUTTONS);

  logic [31:0] held_q [NumStored];
  logic [31:0] held_d [NumStored];
  logic [NumStored-1:0] pe_q, pe_d, re_q, re_d;
  logic [3:0]  cur_q, cur_d, pend_q, pend_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        seen_q, seen_d, dheld_q, dheld_d;

  logic [IdxW-1:0] idx;
  logic [31:0] src_bit, entry, entry_new;
  logic        in_range, is_press, is_release, is_tick, repeat_hit, upd;
  logic [NUM_DIR_BTNS-1:0] dh;
  logic [1:0]  lr_p, lr_n, ud_p, ud_n;
  logic [3:0]  h;

  assign idx        = evt_i.button[IdxW-1:0];
  assign in_range   = {2'b00, evt_i.button} < NumBtnV;
  assign src_bit    = 32'd1 << evt_i.source;
  assign entry      = held_q[idx];
  assign is_press   = evt_i.func == FN_PRESS;
  assign is_release = evt_i.func == FN_RELEASE;
  assign is_tick    = evt_i.func == FN_TICK;
  assign repeat_hit = (entry & src_bit) != 32'd0;
  assign upd        = in_range && ((is_press && !repeat_hit) || is_release);
  assign entry_new  = is_press ? (entry | src_bit) : (entry & ~src_bit);

  always_comb begin
    for (int i = 0; i < NUM_DIR_BTNS; i++) begin
      if (upd && (idx == IdxW'(i))) begin
        dh[i] = |entry_new;
      end else begin
        dh[i] = |held_q[i];
      end
    end
  end

  assign lr_p = 2'(dh[KEY_LEFT]) + 2'(dh[KEY_UP_LEFT]) + 2'(dh[KEY_DOWN_LEFT]);
  assign lr_n = 2'(dh[KEY_RIGHT]) + 2'(dh[KEY_UP_RIGHT]) + 2'(dh[KEY_DOWN_RIGHT]);
  assign ud_p = 2'(dh[KEY_UP]) + 2'(dh[KEY_UP_LEFT]) + 2'(dh[KEY_UP_RIGHT]);
  assign ud_n = 2'(dh[KEY_DOWN]) + 2'(dh[KEY_DOWN_LEFT]) + 2'(dh[KEY_DOWN_RIGHT]);

  always_comb begin
    if (lr_p > lr_n) begin
      h = (ud_p > ud_n) ? HDG_UP_LEFT : (ud_p < ud_n) ? HDG_DOWN_LEFT : HDG_LEFT;
    end else if (lr_p < lr_n) begin
      h = (ud_p > ud_n) ? HDG_UP_RIGHT : (ud_p < ud_n) ? HDG_DOWN_RIGHT : HDG_RIGHT;
    end else begin
      h = (ud_p > ud_n) ? HDG_UP : (ud_p < ud_n) ? HDG_DOWN : HDG_NONE;
    end
  end

  always_comb begin
    held_d  = held_q;
    pe_d    = pe_q;
    re_d    = re_q;
    cur_d   = cur_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    seen_d  = seen_q;
    dheld_d = dheld_q;
    if (fire_i && upd) begin
      held_d[idx] = entry_new;
      if (is_press) begin
        pe_d[idx] = 1'b1;
      end else begin
        re_d[idx] = 1'b1;
      end
      pend_d = h;
      if (hold_frames_i != 8'd0) begin
        if (h == HDG_NONE) begin
          cnt_d = 8'd0;
        end else if (!seen_q || !h[0]) begin
          cur_d = h;
          cnt_d = 8'd0;
        end else begin
          // cardinal after a heading seen since the last tick: wait out the hold
          cnt_d = hold_frames_i;
        end
      end else if (h != HDG_NONE) begin
        cur_d = h;
      end
      seen_d  = seen_q || (h != HDG_NONE);
      dheld_d = h != HDG_NONE;
    end else if (fire_i && is_tick) begin
      if (cnt_q != 8'd0) begin
        cnt_d = cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          cur_d = pend_q;
        end
      end
      seen_d = 1'b0;
      pe_d   = '0;
      re_d   = '0;
    end
  end

  always_comb begin
    res_o.heading       = cur_d;
    res_o.move_active   = pend_d != HDG_NONE;
    res_o.push_res      = seen_d || dheld_d;
    res_o.button_held   = in_range && (held_d[idx] != 32'd0);
    res_o.pressed_edge  = in_range && pe_d[idx];
    res_o.released_edge = in_range && re_d[idx];
    res_o.accepted      = upd || is_tick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStored; i++) begin
        held_q[i] <= '0;
      end
      pe_q    <= '0;
      re_q    <= '0;
      cur_q   <= HDG_UP;
      pend_q  <= HDG_NONE;
      cnt_q   <= 8'd0;
      seen_q  <= 1'b0;
      dheld_q <= 1'b0;
    end else begin
      held_q  <= held_d;
      pe_q    <= pe_d;
      re_q    <= re_d;
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
      dheld_q <= dheld_d;
    end
  end

endmodule

// File: hw/rtl/bdq_checker.sv
`include "button_direction_qualifier_assert.svh"

module bdq_checker
  import bdq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  bdq_chan_if.sink   evt,
  bdq_chan_if.source res,
  bdq_chan_if.sink   cfg
);

  `BDQ_ASSERT(a_res_hold, clk_i, rst_ni, res.valid && !res.ready |=> res.valid && $stable(res.data), "result word changed while stalled")
  `BDQ_ASSERT(a_heading_range, clk_i, rst_ni, res.valid |-> (res.data.heading <= HDG_UP_LEFT), "latched heading out of range")
  `BDQ_ASSERT(a_move_push, clk_i, rst_ni, res.valid && res.data.move_active |-> res.data.push_res, "move active without push")
  `BDQ_ASSERT(a_take_ready, clk_i, rst_ni, !res.valid |-> evt.ready && cfg.ready, "input stalled with result register empty")
  `BDQ_ASSERT_RST(a_rst_quiet, clk_i, !rst_ni |-> !res.valid, "result valid during reset")

endmodule

bind button_direction_qualifier bdq_checker u_bdq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .evt    (evt_i),
  .res    (res_o),
  .cfg    (cfg_i)
);

// File: tb/sv/button_direction_qualifier_tb.sv
module button_direction_qualifier_tb;
  import bdq_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;

  class heading_tracker;
    bit [31:0]  held_mask [BDQ_NUM_BUTTONS];
    bit [31:0]  press_mask [BDQ_NUM_BUTTONS];
    bit [31:0]  release_mask [BDQ_NUM_BUTTONS];
    logic [3:0] cur_heading;
    logic [3:0] next_heading;
    logic [7:0] latch_left;
    logic [7:0] hold_frames;
    bit         move_seen;
    bit         dir_held;
    bdq_res_t   pending_words [$];
    int         words_seen;
    int         errors;

    function new();
      foreach (held_mask[i]) begin
        held_mask[i] = '0;
        press_mask[i] = '0;
        release_mask[i] = '0;
      end
      cur_heading = HDG_UP;
      next_heading = HDG_NONE;
      latch_left = '0;
      hold_frames = '0;
      move_seen = 1'b0;
      dir_held = 1'b0;
      words_seen = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    function int held(int idx);
      return (held_mask[idx] != 0) ? 1 : 0;
    endfunction

    function void resolve();
      int lr;
      int ud;
      logic [3:0] h;
      lr = held(KEY_LEFT) - held(KEY_RIGHT) + held(KEY_UP_LEFT) - held(KEY_UP_RIGHT)
         + held(KEY_DOWN_LEFT) - held(KEY_DOWN_RIGHT);
      ud = held(KEY_UP) - held(KEY_DOWN) + held(KEY_UP_LEFT) + held(KEY_UP_RIGHT)
         - held(KEY_DOWN_LEFT) - held(KEY_DOWN_RIGHT);
      if (lr > 0) h = (ud > 0) ? HDG_UP_LEFT : (ud < 0) ? HDG_DOWN_LEFT : HDG_LEFT;
      else if (lr < 0) h = (ud > 0) ? HDG_UP_RIGHT : (ud < 0) ? HDG_DOWN_RIGHT : HDG_RIGHT;
      else h = (ud > 0) ? HDG_UP : (ud < 0) ? HDG_DOWN : HDG_NONE;
      next_heading = h;
      if (hold_frames != 0) begin
        if (h == HDG_NONE) begin
          latch_left = '0;
        end else if (!move_seen || !h[0]) begin
          cur_heading = h;
          latch_left = '0;
        end else begin
          latch_left = hold_frames;
        end
      end else if (h != HDG_NONE) begin
        cur_heading = h;
      end
      if (h != HDG_NONE) move_seen = 1'b1;
      dir_held = (h != HDG_NONE);
    endfunction

    function void note_event(bdq_evt_t e);
      bit [31:0] bitv;
      bit in_range;
      bit acc;
      int b;
      bdq_res_t r;
      b = int'(e.button);
      bitv = 32'd1 << e.source;
      in_range = b < BDQ_NUM_BUTTONS;
      acc = 1'b0;
      if (e.func == FN_PRESS) begin
        if (in_range && (held_mask[b] & bitv) == 0) begin
          press_mask[b] |= bitv;
          held_mask[b] |= bitv;
          resolve();
          acc = 1'b1;
        end
      end else if (e.func == FN_RELEASE) begin
        if (in_range) begin
          release_mask[b] |= bitv;
          held_mask[b] &= ~bitv;
          resolve();
          acc = 1'b1;
        end
      end else if (e.func == FN_TICK) begin
        if (latch_left != 0) begin
          latch_left--;
          if (latch_left == 0) cur_heading = next_heading;
        end
        move_seen = 1'b0;
        foreach (press_mask[i]) begin
          press_mask[i] = '0;
          release_mask[i] = '0;
        end
        acc = 1'b1;
      end
      r.heading = cur_heading;
      r.move_active = (next_heading != HDG_NONE);
      r.push_res = move_seen || dir_held;
      r.button_held = in_range && held_mask[b] != 0;
      r.pressed_edge = in_range && press_mask[b] != 0;
      r.released_edge = in_range && release_mask[b] != 0;
      r.accepted = acc;
      pending_words.push_back(r);
    endfunction

    task cmp(string fld, int got, int want);
      if (got != want)
        report($sformatf("word %0d %s got %0d want %0d", words_seen, fld, got, want));
    endtask

    task check_word(bdq_res_t r);
      bdq_res_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected result word %h", r));
        return;
      end
      w = pending_words.pop_front();
      cmp("heading", r.heading, w.heading);
      cmp("move_active", r.move_active, w.move_active);
      cmp("push_res", r.push_res, w.push_res);
      cmp("button_held", r.button_held, w.button_held);
      cmp("pressed_edge", r.pressed_edge, w.pressed_edge);
      cmp("released_edge", r.released_edge, w.released_edge);
      cmp("accepted", r.accepted, w.accepted);
      words_seen++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  bdq_chan_if #(.T(bdq_evt_t)) evt_if ();
  bdq_chan_if #(.T(bdq_res_t)) res_if ();
  bdq_chan_if #(.T(bdq_cfg_t)) cfg_if ();

  button_direction_qualifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  heading_tracker sb;
  int burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bdq_evt_t mk_evt(logic [1:0] f, int b, int s);
    bdq_evt_t e;
    e.func = f;
    e.button = b[4:0];
    e.source = s[4:0];
    return e;
  endfunction

  function automatic bdq_evt_t rand_event();
    int r;
    logic [1:0] f;
    int b;
    int s;
    r = $urandom_range(0, 99);
    f = (r < 42) ? FN_PRESS : (r < 80) ? FN_RELEASE : (r < 97) ? FN_TICK : FN_UNUSED;
    b = ($urandom_range(0, 9) < 8) ? $urandom_range(0, NUM_DIR_BTNS - 1)
                                   : $urandom_range(0, 31);
    s = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 31);
    return mk_evt(f, b, s);
  endfunction

  task automatic send_evt(input bdq_evt_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        evt_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    evt_if.valid <= 1'b1;
    evt_if.data <= e;
    do @(posedge clk_i); while (evt_if.ready !== 1'b1);
    sb.note_event(e);
  endtask

  // drain the two-register pipe before touching the register
  task automatic write_hold(input logic [7:0] v);
    evt_if.valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.hold_frames = v;
  endtask

  task automatic run_directed();
    send_evt(mk_evt(FN_PRESS, KEY_UP, 0));
    send_evt(mk_evt(FN_PRESS, KEY_UP, 0));  // key repeat
    send_evt(mk_evt(FN_PRESS, KEY_UP, 31));
    send_evt(mk_evt(FN_PRESS, KEY_RIGHT, 1));
    send_evt(mk_evt(FN_PRESS, KEY_DOWN, 2));
    send_evt(mk_evt(FN_RELEASE, KEY_UP, 0));
    send_evt(mk_evt(FN_RELEASE, KEY_UP, 31));
    send_evt(mk_evt(FN_RELEASE, KEY_RIGHT, 1));
    send_evt(mk_evt(FN_RELEASE, KEY_DOWN, 2));
    send_evt(mk_evt(FN_RELEASE, KEY_LEFT, 5));  // never held
    send_evt(mk_evt(FN_TICK, KEY_LEFT, 0));
    send_evt(mk_evt(FN_UNUSED, 9, 17));
    send_evt(mk_evt(FN_PRESS, 31, 31));
    send_evt(mk_evt(FN_RELEASE, 31, 31));
    send_evt(mk_evt(FN_PRESS, KEY_UP_LEFT, 3));
    send_evt(mk_evt(FN_PRESS, KEY_UP_RIGHT, 10));
    send_evt(mk_evt(FN_PRESS, KEY_DOWN_LEFT, 21));
    send_evt(mk_evt(FN_PRESS, KEY_DOWN_RIGHT, 12));
    send_evt(mk_evt(FN_TICK, 31, 31));
    send_evt(mk_evt(FN_RELEASE, KEY_UP_LEFT, 3));
    send_evt(mk_evt(FN_RELEASE, KEY_DOWN_LEFT, 21));
    send_evt(mk_evt(FN_RELEASE, KEY_UP_RIGHT, 10));
    send_evt(mk_evt(FN_RELEASE, KEY_DOWN_RIGHT, 12));
    send_evt(mk_evt(FN_TICK, KEY_DOWN_RIGHT, 12));
  endtask

  initial begin
    logic [7:0] hold_set [5];
    int waited;
    sb = new();
    rst_ni <= 1'b0;
    evt_if.valid <= 1'b0;
    evt_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    hold_set = '{8'd2, 8'd255, 8'd0, 8'd1, 8'($urandom_range(3, 20))};
    foreach (hold_set[i]) begin
      write_hold(hold_set[i]);
      repeat (400) send_evt(rand_event());
    end
    evt_if.valid <= 1'b0;
    waited = 0;
    while (sb.pending_words.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending_words.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending_words.size()));
    if (sb.errors == 0) begin
      $display("** button_direction_qualifier: PASSED **");
    end else begin
      $display("** button_direction_qualifier: FAILED **");
    end
    $finish;
  end

  // result side: stall mix changes over the run, plus a long hold-off
  initial begin
    int rx_cycle;
    int hold_left;
    int pct;
    rx_cycle = 0;
    hold_left = 0;
    pct = 100;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) sb.check_word(res_if.data);
      rx_cycle++;
      if (rx_cycle % 64 == 0) pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 95);
      if (rx_cycle % 4000 == 1500) hold_left = 300;
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  initial begin
    #5000000;
    $display("** button_direction_qualifier: FAILED **");
    $finish;
  end

endmodule
